// ===== src/bitq_pkg.sv =====
// ----------------------------------------------------------------------------
// bitq_pkg
// Types, constants and helpers shared by the backlight idle and touch
// qualifier.
// ----------------------------------------------------------------------------
package bitq_pkg;

    localparam int FIELD_COORD_W   = 9;
    localparam int LEVEL_W         = 8;
    localparam int TIMEOUT_W       = 24;
    localparam int CFG_DATA_W      = 24;
    localparam int CFG_INDEX_W     = 2;
    localparam int COORD_WIDTH_DEF = 9;

    localparam logic [LEVEL_W-1:0]   FULL_RESET    = 8'd255;
    localparam logic [LEVEL_W-1:0]   FULL_MIN      = 8'd24;
    localparam logic [LEVEL_W-1:0]   DIM_FLOOR     = 8'd8;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd60000;
    localparam int                   DRAG_LIMIT    = 10;

    // x / 5 == (x * 205) >> 10 for every 8-bit x
    localparam logic [LEVEL_W-1:0] DIM_RECIP = 8'd205;
    localparam int                 DIM_SHIFT = 10;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_TOUCH = 2'd1,
        KIND_POLL  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_ON  = 2'd0,
        MODE_DIM = 2'd1,
        MODE_OFF = 2'd2
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FULL_BRIGHTNESS = 2'd0,
        REG_IDLE_MODE       = 2'd1,
        REG_IDLE_TIMEOUT    = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic                     touched;
        logic [FIELD_COORD_W-1:0] touch_x;
        logic [FIELD_COORD_W-1:0] touch_y;
        logic                     allows_sleep;
    } in_item_t;

    typedef struct packed {
        logic                     pressed;
        logic [FIELD_COORD_W-1:0] point_x;
        logic [FIELD_COORD_W-1:0] point_y;
        logic                     dragging;
        logic                     set_level;
        logic [LEVEL_W-1:0]       level;
        logic                     asleep;
    } out_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   full_brightness;
        logic [LEVEL_W-1:0]   dim_level;
        mode_t                idle_mode;
        logic [TIMEOUT_W-1:0] idle_timeout;
    } cfg_t;

    // brightness / 5 with a floor
    function automatic logic [LEVEL_W-1:0] dim_of(input logic [LEVEL_W-1:0] full);
        logic [2*LEVEL_W-1:0] prod;
        logic [LEVEL_W-1:0]   quot;
        prod = {{LEVEL_W{1'b0}}, full} * {{LEVEL_W{1'b0}}, DIM_RECIP};
        quot = LEVEL_W'(prod >> DIM_SHIFT);
        return (quot < DIM_FLOOR) ? DIM_FLOOR : quot;
    endfunction

endpackage

// ===== src/bitq_cfg.sv =====
// ----------------------------------------------------------------------------
// bitq_cfg
// Configuration registers with write-time clamping; the dim level is
// precomputed on each brightness write.
// ----------------------------------------------------------------------------
module bitq_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [bitq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bitq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output bitq_pkg::cfg_t                       cfg
);
    import bitq_pkg::*;

    logic [LEVEL_W-1:0]   full_reg, full_next;
    logic [LEVEL_W-1:0]   dim_reg, dim_next;
    mode_t                mode_reg, mode_next;
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;

    logic [LEVEL_W-1:0] wr_full;
    logic [1:0]         wr_mode;

    always_comb begin
        wr_full = cfg_wdata[LEVEL_W-1:0];
        if (wr_full < FULL_MIN) begin
            wr_full = FULL_MIN;
        end
        wr_mode = cfg_wdata[1:0];

        full_next    = full_reg;
        dim_next     = dim_reg;
        mode_next    = mode_reg;
        timeout_next = timeout_reg;
        if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_FULL_BRIGHTNESS: begin
                    full_next = wr_full;
                    dim_next  = dim_of(wr_full);
                end
                REG_IDLE_MODE: begin
                    case (mode_t'(wr_mode))
                        MODE_ON:  mode_next = MODE_ON;
                        MODE_DIM: mode_next = MODE_DIM;
                        MODE_OFF: mode_next = MODE_OFF;
                        default:  mode_next = MODE_DIM;
                    endcase
                end
                REG_IDLE_TIMEOUT: begin
                    timeout_next = cfg_wdata[TIMEOUT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg    <= FULL_RESET;
            dim_reg     <= dim_of(FULL_RESET);
            mode_reg    <= MODE_DIM;
            timeout_reg <= TIMEOUT_RESET;
        end else begin
            full_reg    <= full_next;
            dim_reg     <= dim_next;
            mode_reg    <= mode_next;
            timeout_reg <= timeout_next;
        end
    end

    assign cfg = '{full_brightness: full_reg, dim_level: dim_reg,
                   idle_mode: mode_reg, idle_timeout: timeout_reg};

endmodule

// ===== src/bitq_core.sv =====
// ----------------------------------------------------------------------------
// bitq_core
// Idle, sleep and touch tracking state, plus the per-item result logic.
// State advances on each transfer out of the input register.
// ----------------------------------------------------------------------------
module bitq_core #(
    parameter int COORD_WIDTH = bitq_pkg::COORD_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  bitq_pkg::in_item_t  item,
    input  bitq_pkg::cfg_t      cfg,
    output bitq_pkg::out_item_t result
);
    import bitq_pkg::*;

    localparam logic [COORD_WIDTH-1:0] DRAG_LIM = COORD_WIDTH'(DRAG_LIMIT);

    logic [TIMEOUT_W-1:0]   idle_count_reg, idle_count_next;
    logic                   sleeping_reg, sleeping_next;
    logic                   finger_down_reg, finger_down_next;
    logic                   moved_far_reg, moved_far_next;
    logic                   swallow_reg, swallow_next;
    logic [COORD_WIDTH-1:0] start_x_reg, start_x_next;
    logic [COORD_WIDTH-1:0] start_y_reg, start_y_next;

    logic [COORD_WIDTH-1:0] cx, cy, dx, dy;
    logic                   far;
    logic                   timed_out;

    always_comb begin
        cx = COORD_WIDTH'(item.touch_x);
        cy = COORD_WIDTH'(item.touch_y);
        dx = (cx > start_x_reg) ? cx - start_x_reg : start_x_reg - cx;
        dy = (cy > start_y_reg) ? cy - start_y_reg : start_y_reg - cy;
        far = (dx > DRAG_LIM) || (dy > DRAG_LIM);
        timed_out = (idle_count_reg >= cfg.idle_timeout);

        idle_count_next  = idle_count_reg;
        sleeping_next    = sleeping_reg;
        finger_down_next = finger_down_reg;
        moved_far_next   = moved_far_reg;
        swallow_next     = swallow_reg;
        start_x_next     = start_x_reg;
        start_y_next     = start_y_reg;
        result           = '0;

        case (kind_t'(item.kind))
            KIND_TICK: begin
                if (!timed_out && idle_count_reg != {TIMEOUT_W{1'b1}}) begin
                    idle_count_next = idle_count_reg + 1'b1;
                end
            end
            KIND_TOUCH: begin
                if (item.touched) begin
                    idle_count_next = '0;
                    sleeping_next   = 1'b0;
                    // waking touch: restore level, hide press until release
                    if (sleeping_reg) begin
                        swallow_next     = 1'b1;
                        result.set_level = 1'b1;
                        result.level     = cfg.full_brightness;
                    end
                    if (!finger_down_reg) begin
                        finger_down_next = 1'b1;
                        moved_far_next   = 1'b0;
                        start_x_next     = cx;
                        start_y_next     = cy;
                    end else if (far) begin
                        moved_far_next = 1'b1;
                    end
                    if (!swallow_next) begin
                        result.pressed = 1'b1;
                        result.point_x = FIELD_COORD_W'(cx);
                        result.point_y = FIELD_COORD_W'(cy);
                    end
                end else begin
                    swallow_next     = 1'b0;
                    finger_down_next = 1'b0;
                end
            end
            KIND_POLL: begin
                if (cfg.idle_mode == MODE_ON || !item.allows_sleep) begin
                    idle_count_next = '0;
                    sleeping_next   = 1'b0;
                    if (sleeping_reg) begin
                        result.set_level = 1'b1;
                        result.level     = cfg.full_brightness;
                    end
                end else if (!sleeping_reg && timed_out) begin
                    sleeping_next    = 1'b1;
                    result.set_level = 1'b1;
                    result.level     = (cfg.idle_mode == MODE_OFF) ? '0 : cfg.dim_level;
                end
            end
            default: ;
        endcase

        result.dragging = moved_far_next;
        result.asleep   = sleeping_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_count_reg  <= '0;
            sleeping_reg    <= 1'b0;
            finger_down_reg <= 1'b0;
            moved_far_reg   <= 1'b0;
            swallow_reg     <= 1'b0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
        end else if (fire) begin
            idle_count_reg  <= idle_count_next;
            sleeping_reg    <= sleeping_next;
            finger_down_reg <= finger_down_next;
            moved_far_reg   <= moved_far_next;
            swallow_reg     <= swallow_next;
            start_x_reg     <= start_x_next;
            start_y_reg     <= start_y_next;
        end
    end

endmodule

// ===== src/backlight_idle_and_touch_qualifier.sv =====
// ----------------------------------------------------------------------------
// backlight_idle_and_touch_qualifier
// Backlight idle timer and touch qualifier, one result per item.
// ----------------------------------------------------------------------------
// Accepts one item (millisecond tick, touch sample or inactivity poll) per
// clock while not stalled and returns exactly one result for each, in order.
// An item passes two registers: the input register, then the output
// register, into which its result is loaded once computed from the tracking
// state. Throughput is one item per cycle, limited only by back-pressure on
// the output; a stalled output holds its result while the input register
// still takes one more item. Configuration writes take effect on the next
// cycle and should be issued while no item is in flight.
module backlight_idle_and_touch_qualifier #(
    parameter int COORD_WIDTH = bitq_pkg::COORD_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  bitq_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output bitq_pkg::out_item_t                m_data,
    input  logic                               cfg_we,
    input  logic [bitq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bitq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import bitq_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    logic      advance;
    logic      fire;
    cfg_t      cfg;
    out_item_t result;

    bitq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bitq_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = s_ready ? s_valid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== src/bitq_checker.sv =====
// ----------------------------------------------------------------------------
// bitq_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bitq_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input bitq_pkg::out_item_t m_data
);
    import bitq_pkg::*;

    // a stalled result holds until its transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no level driven means level field is zero
    a_level_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.set_level |-> m_data.level == '0)
        else $error("level without set_level");

    // awake level is never below the brightness minimum
    a_level_awake: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.set_level && !m_data.asleep |-> m_data.level >= FULL_MIN)
        else $error("wake level below minimum");

    // sleep level is off or at least the dim floor
    a_level_sleep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.set_level && m_data.asleep |->
            m_data.level == '0 || m_data.level >= DIM_FLOOR)
        else $error("sleep level below dim floor");

    // a reported press only comes from a touch, which always wakes
    a_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.pressed |-> !m_data.asleep)
        else $error("press reported while asleep");

endmodule

bind backlight_idle_and_touch_qualifier bitq_checker u_bitq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
